// ===== sv/tcp_flow_sequence_tracker_unit_macros.svh =====
// Assertion macros shared by the block's checking code.
`ifndef TCP_FLOW_SEQUENCE_TRACKER_UNIT_MACROS_SVH
`define TCP_FLOW_SEQUENCE_TRACKER_UNIT_MACROS_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define TFST_ASSERT_SAME(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("tfst check failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define TFST_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("tfst check failed");

`endif

// ===== sv/tfst_pkg.sv =====
package tfst_pkg;

  localparam int BUCKETS      = 256;
  localparam int WAYS         = 4;
  localparam int SAVE_SLOTS   = 8;
  localparam int BUCKET_W     = $clog2(BUCKETS);
  localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W        = $clog2(SAVE_SLOTS + 1);
  localparam int SLOT_W       = (SAVE_SLOTS > 1) ? $clog2(SAVE_SLOTS) : 1;
  localparam int SEG_DEPTH    = BUCKETS * WAYS * SAVE_SLOTS;
  localparam int SEG_AW       = $clog2(SEG_DEPTH);
  localparam int IP_HDR_BYTES = 20;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_AGE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_NO_PAYLOAD = 4'd0,
    ST_INSERTED   = 4'd1,
    ST_REFRESHED  = 4'd2,
    ST_FULL       = 4'd3,
    ST_STORED     = 4'd4,
    ST_ACCEPTED   = 4'd5,
    ST_NO_MATCH   = 4'd6,
    ST_DELETED    = 4'd7,
    ST_EXPIRED    = 4'd8,
    ST_AGE_DONE   = 4'd9
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [15:0] ip_total_len;
    logic [3:0]  tcp_hdr_words;
    logic [31:0] now_sec;
    logic [7:0]  age_bucket;
  } in_word_t;

  typedef struct packed {
    status_t     status;
    logic        last;
    logic [31:0] flow_src_ip;
    logic [31:0] flow_dst_ip;
    logic [15:0] flow_src_port;
    logic [15:0] flow_dst_port;
    logic [2:0]  slot_index;
    logic [3:0]  saved_count;
    logic [31:0] expected_seq;
  } out_word_t;

  typedef struct packed {
    logic [31:0]      src_ip;
    logic [31:0]      dst_ip;
    logic [31:0]      ports;
    logic [31:0]      seq_expect;
    logic [31:0]      last_seen;
    logic [CNT_W-1:0] seg_count;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic read;
    logic eval;
    logic age_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_age;
    logic out_free;
    logic way_expired;
    logic way_last;
  } ctrl_stat_t;

  // Index of the lowest set bit; zero when none is set.
  function automatic logic [WAY_W-1:0] lowest_set(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] idx;
    idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WAY_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== sv/tfst_ctrl.sv =====
module tfst_ctrl import tfst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_AGE   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    item_ready   = (state == S_IDLE);
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (stat.is_age) begin
          state_next = S_AGE;
        end else if (stat.out_free) begin
          cmd.eval   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_AGE: begin
        if (!stat.way_expired || stat.out_free) begin
          cmd.age_step = 1'b1;
          if (stat.way_last) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/tfst_dpath.sv =====
module tfst_dpath import tfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  input  in_word_t    item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  input  logic        result_ready,
  output out_word_t   result
);

  logic [WAYS-1:0]     vmem [BUCKETS];
  row_t                dmem [BUCKETS];
  logic [15:0]         smem [SEG_DEPTH];

  in_word_t            item_q;
  logic [BUCKET_W-1:0] bucket_q;
  logic signed [17:0]  pay_q;
  logic [WAYS-1:0]     vrow;
  row_t                drow;
  logic [WAY_W-1:0]    way_cnt;
  logic [BUCKET_W-1:0] clr_cnt;
  logic [15:0]         timeout;

  logic [BUCKET_W-1:0] hash;
  logic [WAYS-1:0]     tuple_hit, seq_hit;
  logic [WAY_W-1:0]    hit_w, seq_w, free_w;
  logic                pay_pos;
  row_t                row_new;
  logic [WAYS-1:0]     vrow_new;
  out_word_t           res_eval, res_exp, res_done;
  way_t                e;
  logic                seg_we;
  logic [SEG_AW-1:0]   seg_addr;
  logic [31:0]         age_diff;

  function automatic out_word_t entry_res(input status_t st, input way_t w,
                                          input logic [2:0] slot, input logic lst);
    out_word_t r;
    r.status        = st;
    r.last          = lst;
    r.flow_src_ip   = w.src_ip;
    r.flow_dst_ip   = w.dst_ip;
    r.flow_src_port = w.ports[31:16];
    r.flow_dst_port = w.ports[15:0];
    r.slot_index    = slot;
    r.saved_count   = 4'(w.seg_count);
    r.expected_seq  = w.seq_expect;
    return r;
  endfunction

  assign hash = BUCKET_W'(item.src_ip ^ item.dst_ip
                          ^ {16'd0, item.src_port ^ item.dst_port});
  assign pay_pos = !pay_q[17] && (pay_q != '0);

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tuple_hit[w] = vrow[w] && (drow[w].src_ip == item_q.src_ip)
                     && (drow[w].dst_ip == item_q.dst_ip)
                     && (drow[w].ports == {item_q.src_port, item_q.dst_port});
      seq_hit[w]   = tuple_hit[w] && (drow[w].seq_expect == item_q.seq_num);
    end
  end

  assign hit_w  = lowest_set(tuple_hit);
  assign seq_w  = lowest_set(seq_hit);
  assign free_w = lowest_set(~vrow);

  always_comb begin
    row_new  = drow;
    vrow_new = vrow;
    seg_we   = 1'b0;
    e        = drow[seq_w];
    res_eval.status        = ST_NO_MATCH;
    res_eval.last          = 1'b1;
    res_eval.flow_src_ip   = item_q.src_ip;
    res_eval.flow_dst_ip   = item_q.dst_ip;
    res_eval.flow_src_port = item_q.src_port;
    res_eval.flow_dst_port = item_q.dst_port;
    res_eval.slot_index    = '0;
    res_eval.saved_count   = '0;
    res_eval.expected_seq  = '0;
    case (item_q.kind)
      KIND_OPEN: begin
        if (|tuple_hit) begin
          row_new[hit_w].last_seen = item_q.now_sec;
          res_eval = entry_res(ST_REFRESHED, drow[hit_w], 3'd0, 1'b1);
        end else if (|(~vrow)) begin
          e.src_ip     = item_q.src_ip;
          e.dst_ip     = item_q.dst_ip;
          e.ports      = {item_q.src_port, item_q.dst_port};
          e.seq_expect = item_q.seq_num + 32'd1;
          e.last_seen  = item_q.now_sec;
          e.seg_count  = '0;
          row_new[free_w]  = e;
          vrow_new[free_w] = 1'b1;
          res_eval = entry_res(ST_INSERTED, e, 3'd0, 1'b1);
        end else begin
          res_eval.status = ST_FULL;
        end
      end
      KIND_DATA: begin
        if (!pay_pos) begin
          res_eval.status = ST_NO_PAYLOAD;
        end else if (|seq_hit) begin
          e.seq_expect = item_q.seq_num + 32'(pay_q);
          if (e.seg_count >= CNT_W'(SAVE_SLOTS)) begin
            res_eval = entry_res(ST_ACCEPTED, e, 3'd0, 1'b1);
          end else begin
            seg_we      = 1'b1;
            e.seg_count = e.seg_count + CNT_W'(1);
            res_eval    = entry_res(ST_STORED, e, 3'(drow[seq_w].seg_count), 1'b1);
          end
          row_new[seq_w] = e;
        end
      end
      KIND_CLOSE: begin
        if (|tuple_hit) begin
          vrow_new[hit_w] = 1'b0;
          res_eval = entry_res(ST_DELETED, drow[hit_w], 3'd0, 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  assign seg_addr = {bucket_q, seq_w, drow[seq_w].seg_count[SLOT_W-1:0]};

  assign age_diff = item_q.now_sec - drow[way_cnt].last_seen;
  assign res_exp  = entry_res(ST_EXPIRED, drow[way_cnt], 3'd0, 1'b0);

  always_comb begin
    res_done        = '0;
    res_done.status = ST_AGE_DONE;
    res_done.last   = 1'b1;
  end

  assign stat.clear_last  = (clr_cnt == BUCKET_W'(BUCKETS - 1));
  assign stat.is_age      = (item_q.kind == KIND_AGE);
  assign stat.out_free    = !result_valid || result_ready;
  assign stat.way_expired = vrow[way_cnt] && (age_diff > {16'd0, timeout});
  assign stat.way_last    = (way_cnt == WAY_W'(WAYS - 1));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      timeout      <= TIMEOUT_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + BUCKET_W'(1);
      end
      if (cfg_we) begin
        timeout <= cfg_data;
      end
      if (cmd.eval || cmd.finish || (cmd.age_step && stat.way_expired)) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q   <= item;
      bucket_q <= (item.kind == KIND_AGE) ? item.age_bucket[BUCKET_W-1:0] : hash;
      pay_q    <= $signed({2'b00, item.ip_total_len}) - 18'sd20
                  - $signed({12'd0, item.tcp_hdr_words, 2'b00});
    end
    if (cmd.read) begin
      vrow    <= vmem[bucket_q];
      drow    <= dmem[bucket_q];
      way_cnt <= '0;
    end
    if (cmd.age_step) begin
      way_cnt <= way_cnt + WAY_W'(1);
      if (stat.way_expired) begin
        vrow[way_cnt] <= 1'b0;
      end
    end
    if (cmd.eval) begin
      result <= res_eval;
    end else if (cmd.age_step && stat.way_expired) begin
      result <= res_exp;
    end else if (cmd.finish) begin
      result <= res_done;
    end
  end

  // Table memories.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vmem[clr_cnt] <= '0;
    end else if (cmd.eval) begin
      vmem[bucket_q] <= vrow_new;
    end else if (cmd.finish) begin
      vmem[bucket_q] <= vrow;
    end
    if (cmd.eval) begin
      dmem[bucket_q] <= row_new;
    end
    if (cmd.eval && seg_we) begin
      smem[seg_addr] <= pay_q[15:0];
    end
  end

endmodule

// ===== sv/tcp_flow_sequence_tracker_unit.sv =====
// TCP flow sequence tracker.
// Input words arrive on item_valid/item_ready as in_word_t: open, data, close or
// age requests. Result words leave on result_valid/result_ready as out_word_t;
// every request gives exactly one result word except an age request, which gives
// one expired word per evicted flow followed by an age-done word. The word that
// ends a request carries last set.
// The idle timeout register is written on cfg_valid/cfg_ready, always ready.
// Flows live in a bucket-row table: one memory read of a row, then compare and
// write-back. For open, data and close requests the row is read, the compare
// registers the result word and writes the row back, and no new request is taken
// until that is done. An age request scans one way per cycle, pausing on an
// expired way while the result register is still full; its age-done word is
// loaded after the last way, and the next request is taken only after that.
// After reset the block sweeps the valid memory, one bucket per cycle, over all
// BUCKETS buckets (256); item_ready stays low during that sweep.
// A stalled receiver holds the result register; the block waits for it only when
// it has another result word to load.
`include "tcp_flow_sequence_tracker_unit_macros.svh"

module tcp_flow_sequence_tracker_unit import tfst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  in_word_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_word_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // The timeout register accepts writes at any time.
  assign cfg_ready = 1'b1;

  tfst_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tfst_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .item         (item),
    .cfg_we       (cfg_valid),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // No request is taken while the valid memory is being swept.
  `TFST_ASSERT_SAME(a_no_accept_in_clear, clk, rst, cmd.clear, !item_ready)
  // A request occupies the block for at least the read cycle.
  `TFST_ASSERT_NEXT(a_busy_after_accept, clk, rst, item_valid && item_ready, !item_ready)
  // The age-done word always closes its request.
  `TFST_ASSERT_SAME(a_age_done_last, clk, rst,
    result_valid && (result.status == ST_AGE_DONE), result.last)

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for the TCP flow table: words go in through a stalling sender, every
// predicted result is queued, and a checker compares each result word with the
// oldest prediction, field by field.
module testbench;
  import tfst_pkg::*;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  in_word_t    item;
  logic        result_valid;
  logic        result_ready;
  out_word_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  tcp_flow_sequence_tracker_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IN_W = $bits(in_word_t);

  // Shadow flow table kept by the predictor.
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_sip   [ENTRIES];
  logic [31:0] tbl_dip   [ENTRIES];
  logic [31:0] tbl_ports [ENTRIES];
  logic [31:0] tbl_next  [ENTRIES];
  logic [31:0] tbl_seen  [ENTRIES];
  logic [3:0]  tbl_cnt   [ENTRIES];
  logic [15:0] timeout_shadow;

  out_word_t pending_results[$];
  int        errors;
  int        cycles;

  // A small pool of live tuples lets random traffic hit existing flows.
  in_word_t  tuple_pool[$];

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL tcp_flow_sequence_tracker_unit");
      $finish;
    end
  end

  function automatic out_word_t entry_word(status_t st, int i, logic [2:0] slot);
    out_word_t w;
    w.status = st;
    w.last = 1'b1;
    w.flow_src_ip = tbl_sip[i];
    w.flow_dst_ip = tbl_dip[i];
    w.flow_src_port = tbl_ports[i][31:16];
    w.flow_dst_port = tbl_ports[i][15:0];
    w.slot_index = slot;
    w.saved_count = tbl_cnt[i];
    w.expected_seq = tbl_next[i];
    return w;
  endfunction

  function automatic out_word_t echo_word(status_t st, in_word_t it);
    out_word_t w;
    w = '0;
    w.status = st;
    w.last = 1'b1;
    w.flow_src_ip = it.src_ip;
    w.flow_dst_ip = it.dst_ip;
    w.flow_src_port = it.src_port;
    w.flow_dst_port = it.dst_port;
    return w;
  endfunction

  // Predicts the result words of one request and updates the shadow table.
  task automatic predict_flow_update(in_word_t it);
    logic [31:0] ports;
    int          base;
    int          hit;
    int          i;
    int          pay;
    out_word_t   w;
    ports = {it.src_port, it.dst_port};
    base = int'((it.src_ip ^ it.dst_ip ^ {16'd0, it.src_port ^ it.dst_port})
                % BUCKETS) * WAYS;
    hit = -1;
    for (int k = WAYS - 1; k >= 0; k--) begin
      i = base + k;
      if (tbl_valid[i] && tbl_sip[i] == it.src_ip && tbl_dip[i] == it.dst_ip &&
          tbl_ports[i] == ports) begin
        hit = i;
      end
    end
    case (it.kind)
      KIND_OPEN: begin
        if (hit >= 0) begin
          tbl_seen[hit] = it.now_sec;
          pending_results.push_back(entry_word(ST_REFRESHED, hit, 3'd0));
        end else begin
          for (int k = WAYS - 1; k >= 0; k--) begin
            if (!tbl_valid[base + k]) hit = base + k;
          end
          if (hit < 0) begin
            pending_results.push_back(echo_word(ST_FULL, it));
          end else begin
            tbl_valid[hit] = 1'b1;
            tbl_sip[hit] = it.src_ip;
            tbl_dip[hit] = it.dst_ip;
            tbl_ports[hit] = ports;
            tbl_next[hit] = it.seq_num + 32'd1;
            tbl_seen[hit] = it.now_sec;
            tbl_cnt[hit] = 4'd0;
            pending_results.push_back(entry_word(ST_INSERTED, hit, 3'd0));
          end
        end
      end
      KIND_DATA: begin
        pay = int'(it.ip_total_len) - IP_HDR_BYTES - 4 * int'(it.tcp_hdr_words);
        if (pay <= 0) begin
          pending_results.push_back(echo_word(ST_NO_PAYLOAD, it));
        end else begin
          // The data match also needs the expected sequence, so it may pick a
          // later way than the plain tuple lookup would.
          hit = -1;
          for (int k = WAYS - 1; k >= 0; k--) begin
            i = base + k;
            if (tbl_valid[i] && tbl_sip[i] == it.src_ip && tbl_dip[i] == it.dst_ip
                && tbl_ports[i] == ports && tbl_next[i] == it.seq_num) begin
              hit = i;
            end
          end
          if (hit < 0) begin
            pending_results.push_back(echo_word(ST_NO_MATCH, it));
          end else begin
            tbl_next[hit] = it.seq_num + 32'(pay);
            if (tbl_cnt[hit] >= SAVE_SLOTS) begin
              pending_results.push_back(entry_word(ST_ACCEPTED, hit, 3'd0));
            end else begin
              tbl_cnt[hit] = tbl_cnt[hit] + 4'd1;
              pending_results.push_back(entry_word(ST_STORED, hit,
                                                   3'(tbl_cnt[hit] - 4'd1)));
            end
          end
        end
      end
      KIND_CLOSE: begin
        if (hit < 0) begin
          pending_results.push_back(echo_word(ST_NO_MATCH, it));
        end else begin
          pending_results.push_back(entry_word(ST_DELETED, hit, 3'd0));
          tbl_valid[hit] = 1'b0;
        end
      end
      default: begin
        base = int'(it.age_bucket % BUCKETS) * WAYS;
        for (int k = 0; k < WAYS; k++) begin
          i = base + k;
          if (tbl_valid[i] && (it.now_sec - tbl_seen[i]) > {16'd0, timeout_shadow})
          begin
            w = entry_word(ST_EXPIRED, i, 3'd0);
            w.last = 1'b0;
            pending_results.push_back(w);
            tbl_valid[i] = 1'b0;
          end
        end
        w = '0;
        w.status = ST_AGE_DONE;
        w.last = 1'b1;
        pending_results.push_back(w);
      end
    endcase
  endtask

  // Sends one request word after a random gap, predicting at acceptance.
  // Valid stays high after acceptance when the next word follows at once.
  task automatic send_request(in_word_t it);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    predict_flow_update(it);
  endtask

  // The receiver draws a stall length for each result word it takes.
  initial begin
    int stall;
    result_ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result word %h", $time, result);
        errors <= errors + 1;
      end else begin
        exp_w = pending_results.pop_front();
        if (result.status !== exp_w.status ||
            result.last !== exp_w.last ||
            result.flow_src_ip !== exp_w.flow_src_ip ||
            result.flow_dst_ip !== exp_w.flow_dst_ip ||
            result.flow_src_port !== exp_w.flow_src_port ||
            result.flow_dst_port !== exp_w.flow_dst_port ||
            result.slot_index !== exp_w.slot_index ||
            result.saved_count !== exp_w.saved_count ||
            result.expected_seq !== exp_w.expected_seq) begin
          $display("%0t mismatch expected %h actual %h", $time, exp_w, result);
          errors <= errors + 1;
        end
      end
    end
  end

  // Drops valid, waits for every predicted word, then for the age scan to
  // settle, so the block is idle before a register write.
  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 + WAYS + 4) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    drain_results();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    timeout_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t make_word(kind_t k, logic [31:0] sip, logic [31:0] dip,
                                         logic [15:0] sp, logic [15:0] dp);
    in_word_t it;
    it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.kind = k;
    it.src_ip = sip;
    it.dst_ip = dip;
    it.src_port = sp;
    it.dst_port = dp;
    return it;
  endfunction

  // Directed: field extremes, every kind, a full bucket, the slot limit,
  // no-payload boundaries, a wrong sequence and wrapping age.
  task automatic test_directed();
    in_word_t it;
    logic [31:0] nxt;
    it = make_word(KIND_OPEN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    it.seq_num = 32'hFFFF_FFFF;
    it.now_sec = 32'hFFFF_FFF0;
    send_request(it);
    send_request(it);
    // Five more flows in bucket 0: the last two find the bucket full.
    for (int k = 1; k <= 5; k++) begin
      it = make_word(KIND_OPEN, 32'(k), 32'(k), 16'd0, 16'd0);
      it.seq_num = 32'd100;
      it.now_sec = 32'd10;
      send_request(it);
    end
    // Payload exactly zero, then far below zero.
    it = make_word(KIND_DATA, 32'd1, 32'd1, 16'd0, 16'd0);
    it.ip_total_len = 16'd40; it.tcp_hdr_words = 4'd5; it.seq_num = 32'd101;
    send_request(it);
    it.ip_total_len = 16'd0; it.tcp_hdr_words = 4'd15;
    send_request(it);
    // Wrong sequence number.
    it.ip_total_len = 16'd41; it.seq_num = 32'd7; it.tcp_hdr_words = 4'd5;
    send_request(it);
    // Ten in-order segments fill all slots and then overflow.
    nxt = 32'd101;
    for (int k = 0; k < 10; k++) begin
      it.seq_num = nxt;
      it.ip_total_len = (k == 9) ? 16'hFFFF : 16'd60;
      it.tcp_hdr_words = 4'd0;
      send_request(it);
      nxt = nxt + 32'(int'(it.ip_total_len) - IP_HDR_BYTES);
    end
    it = make_word(KIND_CLOSE, 32'd2, 32'd2, 16'd0, 16'd0);
    send_request(it);
    send_request(it);
    // Age bucket 0 at a time that has wrapped past the first flow's stamp.
    it = make_word(KIND_AGE, 32'd0, 32'd0, 16'd0, 16'd0);
    it.age_bucket = 8'd0; it.now_sec = 32'd5;
    send_request(it);
    it.age_bucket = 8'hFF;
    send_request(it);
  endtask

  task automatic test_timeout_settings();
    in_word_t it;
    logic [15:0] vals[3];
    vals = '{16'd0, 16'hFFFF, 16'd30};
    foreach (vals[v]) begin
      write_timeout(vals[v]);
      it = make_word(KIND_OPEN, 32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd81);
      it.now_sec = 32'd1000;
      send_request(it);
      it.kind = KIND_AGE;
      it.age_bucket = 8'(it.src_ip ^ it.dst_ip ^ {16'd0, it.src_port ^ it.dst_port});
      it.now_sec = 32'd1000 + 32'(vals[v]);
      send_request(it);
      it.now_sec = it.now_sec + 32'd1;
      send_request(it);
    end
  endtask

  // Random traffic, mostly on a small pool of tuples so that opens, in-order
  // data, closes and ages act on live flows.
  task automatic test_random_traffic(int count);
    in_word_t it;
    in_word_t t;
    int idx;
    int i;
    for (int n = 0; n < count; n++) begin
      if (n % 150 == 75) write_timeout(16'($urandom_range(0, 60)));
      if (tuple_pool.size() < 24 || $urandom_range(0, 9) == 0) begin
        t = make_word(KIND_OPEN, $urandom, $urandom, 16'($urandom), 16'($urandom));
        // Many tuples share a handful of buckets to exercise full buckets.
        t.dst_ip[7:0] = t.src_ip[7:0] ^ t.src_port[7:0] ^ t.dst_port[7:0]
                        ^ 8'($urandom_range(0, 3));
        tuple_pool.push_back(t);
        if (tuple_pool.size() > 40) tuple_pool.delete(0);
      end
      idx = $urandom_range(0, tuple_pool.size() - 1);
      it = make_word(kind_t'($urandom_range(0, 3)), tuple_pool[idx].src_ip,
                     tuple_pool[idx].dst_ip, tuple_pool[idx].src_port,
                     tuple_pool[idx].dst_port);
      it.now_sec = 32'(n) + $urandom_range(0, 50);
      if ($urandom_range(0, 3) == 0) it.kind = KIND_DATA;
      if (it.kind == KIND_DATA) begin
        it.ip_total_len = 16'($urandom_range(0, 120));
        it.tcp_hdr_words = 4'($urandom_range(0, 15));
        // Use the predicted next sequence most of the time.
        if ($urandom_range(0, 4) != 0) begin
          for (int k = 0; k < WAYS; k++) begin
            i = int'((it.src_ip ^ it.dst_ip ^ {16'd0, it.src_port ^ it.dst_port})
                     % BUCKETS) * WAYS + k;
            if (tbl_valid[i] && tbl_sip[i] == it.src_ip && tbl_dip[i] == it.dst_ip
                && tbl_ports[i] == {it.src_port, it.dst_port}) begin
              it.seq_num = tbl_next[i];
            end
          end
        end
      end
      if (it.kind == KIND_AGE) begin
        if ($urandom_range(0, 3) != 0) begin
          it.age_bucket = 8'(it.src_ip ^ it.dst_ip ^ {16'd0, it.src_port ^ it.dst_port});
        end
      end
      if ($urandom_range(0, 19) == 0) begin
        it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end
      send_request(it);
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    timeout_shadow = TIMEOUT_RESET;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_timeout_settings();
    test_random_traffic(500);
    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS tcp_flow_sequence_tracker_unit");
    end else begin
      $display("FAIL tcp_flow_sequence_tracker_unit");
    end
    $finish;
  end
endmodule

// ===== tcp_flow_sequence_tracker_unit.f =====
+incdir+sv
sv/tfst_pkg.sv
sv/tfst_ctrl.sv
sv/tfst_dpath.sv
sv/tcp_flow_sequence_tracker_unit.sv
dv/testbench.sv
